// ===== design/dtfp_pkg.sv =====
// Shared types, constants and helper functions of the decimal text to fixed-point parser.
package dtfp_pkg;

    // Default number of fraction digits that are kept.
    localparam int unsigned FRACTION_DIGITS_DEF = 9;

    // The result is scaled by ten to this power.
    localparam int unsigned SCALE_DIGITS = 9;

    // Field and accumulator widths.
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned INT_W   = 34;
    localparam int unsigned FRAC_W  = 30;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned RND_W   = 5;
    localparam int unsigned POW_W   = 30;
    localparam int unsigned SCALE_W = 27;
    localparam int unsigned ODD_W   = 21;

    // Largest integer part that still fits the scaled result.
    localparam logic [INT_W-1:0] INT_LIMIT = 34'd9223372036;

    // Rounding digit marker and threshold.
    localparam logic [RND_W-1:0] ROUND_NONE = 5'd16;
    localparam logic [RND_W-1:0] ROUND_HALF = 5'd5;

    // 10^9 is split into 2^9 and 5^9 so the integer product stays narrow.
    localparam logic [ODD_W-1:0] SCALE_ODD   = 21'd1953125;
    localparam int unsigned      SCALE_SHIFT = SCALE_DIGITS;

    // Saturated magnitude.
    localparam logic [VALUE_W-1:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;

    // Parse phases.
    typedef enum logic [3:0] {
        PH_LEAD = 4'b0001,
        PH_INT  = 4'b0010,
        PH_FRAC = 4'b0100,
        PH_DONE = 4'b1000
    } t_phase;

    // One input request.
    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              last_char;
    } t_in_req;

    // One result request.
    typedef struct packed {
        logic signed [VALUE_W-1:0] fixed_value;
        logic                      value_changed;
        logic                      overflow;
    } t_out_req;

    // Parse state captured on the final character.
    typedef struct packed {
        logic             is_negative;
        logic             overflow_seen;
        logic [INT_W-1:0] int_acc;
        logic [FRAC_W-1:0] frac_acc;
        logic [CNT_W-1:0] frac_cnt;
        logic [RND_W-1:0] round_digit;
    } t_snap;

    // Space, tab, line feed, vertical tab, form feed or carriage return.
    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Powers of ten from 10^0 to 10^9.
    function automatic logic [POW_W-1:0] pow10(input logic [CNT_W-1:0] n);
        logic [POW_W-1:0] p;
        unique case (n)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            4'd9:    p = 30'd1000000000;
            default: p = 30'd0;
        endcase
        return p;
    endfunction

endpackage

// ===== design/dtfp_parse.sv =====
// Input register and per-character parse state machine with the end-of-number capture.
module dtfp_parse #(
    parameter int unsigned FRACTION_DIGITS = dtfp_pkg::FRACTION_DIGITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  dtfp_pkg::t_in_req i_in_data,
    output logic            o_snap_valid,
    output dtfp_pkg::t_snap o_snap,
    input  logic            i_snap_ready
);
    import dtfp_pkg::*;

    // Input register.
    logic    r_in_valid;
    t_in_req r_in;

    // Parse state.
    t_phase            r_phase, n_phase;
    logic              r_neg, n_neg;
    logic [INT_W-1:0]  r_int, n_int;
    logic [FRAC_W-1:0] r_frac, n_frac;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [RND_W-1:0]  r_rnd, n_rnd;
    logic              r_ovf, n_ovf;

    // Captured state of a finished number.
    logic  r_snap_valid;
    t_snap r_snap;

    logic [CHAR_W-1:0] c;
    logic [3:0]        digit;
    logic [INT_W+3:0]  int_next;
    logic [FRAC_W+3:0] frac_next;
    logic              int_sat;
    logic              do_int;
    logic              snap_ready;
    logic              parse_fire;
    logic              in_ready;

    assign c     = r_in.text_char;
    assign digit = r_in.text_char[3:0];

    // Multiply by ten and add the digit.
    assign int_next  = {1'b0, r_int, 3'b000} + {3'b000, r_int, 1'b0} + (INT_W+4)'(digit);
    assign int_sat   = int_next > (INT_W+4)'(INT_LIMIT);
    assign frac_next = {1'b0, r_frac, 3'b000} + {3'b000, r_frac, 1'b0} + (FRAC_W+4)'(digit);

    // Next parse state for the character in the input register.
    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_int   = r_int;
        n_frac  = r_frac;
        n_cnt   = r_cnt;
        n_rnd   = r_rnd;
        n_ovf   = r_ovf;
        do_int  = 1'b0;
        unique case (r_phase)
            PH_LEAD: begin
                if (!is_space(c)) begin
                    n_phase = PH_INT;
                    if (c == CH_MINUS) begin
                        n_neg = 1'b1;
                    end else if (c != CH_PLUS) begin
                        do_int = 1'b1;
                    end
                end
            end
            PH_INT: begin
                do_int = 1'b1;
            end
            PH_FRAC: begin
                if (!is_digit(c)) begin
                    n_phase = PH_DONE;
                end else if (r_cnt < CNT_W'(FRACTION_DIGITS)) begin
                    n_frac = frac_next[FRAC_W-1:0];
                    n_cnt  = r_cnt + 1'b1;
                end else if (r_rnd == ROUND_NONE) begin
                    n_rnd = {1'b0, digit};
                end
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase
        // Integer digits; whitespace between them is skipped.
        if (do_int && !is_space(c)) begin
            if (is_digit(c)) begin
                if (int_sat) begin
                    n_int = INT_LIMIT;
                    n_ovf = 1'b1;
                end else begin
                    n_int = int_next[INT_W-1:0];
                end
            end else if ((c == CH_DOT) || (c == CH_COMMA)) begin
                n_phase = PH_FRAC;
            end else begin
                n_phase = PH_DONE;
            end
        end
    end

    // Handshake: a final character waits until the capture slot is free.
    assign snap_ready = !r_snap_valid || i_snap_ready;
    assign parse_fire = r_in_valid && (!r_in.last_char || snap_ready);
    assign in_ready   = !r_in_valid || parse_fire;
    assign o_in_stall = !in_ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Parse state; the final character restarts the parse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_neg   <= 1'b0;
            r_int   <= '0;
            r_frac  <= '0;
            r_cnt   <= '0;
            r_rnd   <= ROUND_NONE;
            r_ovf   <= 1'b0;
        end else if (parse_fire) begin
            if (r_in.last_char) begin
                r_phase <= PH_LEAD;
                r_neg   <= 1'b0;
                r_int   <= '0;
                r_frac  <= '0;
                r_cnt   <= '0;
                r_rnd   <= ROUND_NONE;
                r_ovf   <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_neg   <= n_neg;
                r_int   <= n_int;
                r_frac  <= n_frac;
                r_cnt   <= n_cnt;
                r_rnd   <= n_rnd;
                r_ovf   <= n_ovf;
            end
        end
    end

    // Capture of the finished number.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (snap_ready) begin
            r_snap_valid <= parse_fire && r_in.last_char;
        end
        if (parse_fire && r_in.last_char) begin
            r_snap.is_negative   <= n_neg;
            r_snap.overflow_seen <= n_ovf;
            r_snap.int_acc       <= n_int;
            r_snap.frac_acc      <= n_frac;
            r_snap.frac_cnt      <= n_cnt;
            r_snap.round_digit   <= n_rnd;
        end
    end

    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;

endmodule

// ===== design/dtfp_result.sv =====
// Result pipeline: rounding, scaling multiplies, saturation, sign and change detection.
module dtfp_result #(
    parameter int unsigned FRACTION_DIGITS = dtfp_pkg::FRACTION_DIGITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_snap_valid,
    input  dtfp_pkg::t_snap    i_snap,
    output logic               o_snap_ready,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output dtfp_pkg::t_out_req o_out_data
);
    import dtfp_pkg::*;

    // Fraction value at which rounding carries into the integer part.
    localparam logic [FRAC_W:0] FRAC_LIMIT = (FRAC_W+1)'(pow10(CNT_W'(FRACTION_DIGITS)));
    localparam logic [INT_W:0]  IP_LIMIT   = (INT_W+1)'(INT_LIMIT) + 1'b1;

    // Rounding stage registers.
    logic               r_rd_valid;
    logic [INT_W-1:0]   r_rd_ip;
    logic [FRAC_W-1:0]  r_rd_fp;
    logic [SCALE_W-1:0] r_rd_scale;
    logic               r_rd_neg;
    logic               r_rd_ovf;

    // Multiply stage registers.
    logic                   r_mu_valid;
    logic [INT_W+ODD_W-1:0] r_mu_int;
    logic [FRAC_W-1:0]      r_mu_frac;
    logic                   r_mu_neg;
    logic                   r_mu_ovf;

    // Sum stage registers.
    logic               r_sm_valid;
    logic [VALUE_W-1:0] r_sm_mag;
    logic               r_sm_neg;
    logic               r_sm_ovf;

    // Output register and the last value given.
    logic               r_out_valid;
    t_out_req           r_out;
    logic [VALUE_W-1:0] r_held;

    logic rd_ready, mu_ready, sm_ready, out_ready;

    logic                   round_up;
    logic [FRAC_W:0]        fp_inc;
    logic                   fp_wrap;
    logic [INT_W:0]         ip_rnd;
    logic [INT_W:0]         ip_clip;
    logic [FRAC_W-1:0]      fp_rnd;
    logic [CNT_W-1:0]       cnt_clip;
    logic [POW_W-1:0]       scale_full;
    logic [INT_W+ODD_W-1:0] int_prod;
    logic [FRAC_W+SCALE_W-1:0] frac_prod;
    logic [VALUE_W-1:0]     sum;
    logic                   sum_sat;
    logic [VALUE_W-1:0]     result;

    // Stage handshakes.
    assign out_ready    = !r_out_valid || !i_out_stall;
    assign sm_ready     = !r_sm_valid || out_ready;
    assign mu_ready     = !r_mu_valid || sm_ready;
    assign rd_ready     = !r_rd_valid || mu_ready;
    assign o_snap_ready = rd_ready;

    // Round the kept fraction, carry into the integer part, pick the fraction scale.
    always_comb begin
        round_up = (i_snap.round_digit != ROUND_NONE) && (i_snap.round_digit >= ROUND_HALF);
        fp_inc   = {1'b0, i_snap.frac_acc} + 1'b1;
        fp_wrap  = fp_inc >= FRAC_LIMIT;
        fp_rnd   = i_snap.frac_acc;
        ip_rnd   = {1'b0, i_snap.int_acc};
        if (round_up) begin
            if (fp_wrap) begin
                fp_rnd = '0;
                ip_rnd = {1'b0, i_snap.int_acc} + 1'b1;
            end else begin
                fp_rnd = fp_inc[FRAC_W-1:0];
            end
        end
        ip_clip  = (ip_rnd > IP_LIMIT) ? IP_LIMIT : ip_rnd;
        cnt_clip = (i_snap.frac_cnt > CNT_W'(SCALE_DIGITS)) ? CNT_W'(SCALE_DIGITS)
                                                             : i_snap.frac_cnt;
        scale_full = (cnt_clip == '0) ? '0 : pow10(CNT_W'(SCALE_DIGITS) - cnt_clip);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else if (rd_ready) begin
            r_rd_valid <= i_snap_valid;
        end
        if (rd_ready && i_snap_valid) begin
            r_rd_ip    <= ip_clip[INT_W-1:0];
            r_rd_fp    <= fp_rnd;
            r_rd_scale <= scale_full[SCALE_W-1:0];
            r_rd_neg   <= i_snap.is_negative;
            r_rd_ovf   <= i_snap.overflow_seen;
        end
    end

    // Scaling products; the integer part takes 5^9 here and 2^9 as a shift later.
    assign int_prod  = r_rd_ip * SCALE_ODD;
    assign frac_prod = r_rd_fp * r_rd_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mu_valid <= 1'b0;
        end else if (mu_ready) begin
            r_mu_valid <= r_rd_valid;
        end
        if (mu_ready && r_rd_valid) begin
            r_mu_int  <= int_prod;
            r_mu_frac <= frac_prod[FRAC_W-1:0];
            r_mu_neg  <= r_rd_neg;
            r_mu_ovf  <= r_rd_ovf;
        end
    end

    // Combine both parts and saturate above 2^63-1.
    assign sum     = {r_mu_int, SCALE_SHIFT'(0)} + VALUE_W'(r_mu_frac);
    assign sum_sat = r_mu_ovf || sum[VALUE_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sm_valid <= 1'b0;
        end else if (sm_ready) begin
            r_sm_valid <= r_mu_valid;
        end
        if (sm_ready && r_mu_valid) begin
            r_sm_mag <= sum_sat ? MAG_MAX : sum;
            r_sm_neg <= r_mu_neg;
            r_sm_ovf <= sum_sat;
        end
    end

    // Apply the sign and compare with the value given before.
    assign result = r_sm_neg ? (VALUE_W'(0) - r_sm_mag) : r_sm_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_held      <= '0;
        end else begin
            if (out_ready) begin
                r_out_valid <= r_sm_valid;
            end
            if (out_ready && r_sm_valid) begin
                r_held <= result;
            end
        end
        if (out_ready && r_sm_valid) begin
            r_out.fixed_value   <= result;
            r_out.value_changed <= result != r_held;
            r_out.overflow      <= r_sm_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== design/decimal_text_to_fixed_parser.sv =====
// Top level of the decimal text to fixed-point parser.
// The block takes one text byte per cycle while o_in_stall is low and keeps taking bytes
// while a result waits at the output; a byte marked last is held until the capture slot
// is free. The per-character update (multiply by ten and add) is a single register stage.
// A result for the byte marked last passes the input register, parse, rounding, scaling
// multiply, sum and saturation, and sign and change flag stages, and waits while stalled.
// The value is the parsed number times 10^9 in two's complement; magnitudes above
// 2^63-1 saturate and raise overflow, and value_changed compares with the previous result.
module decimal_text_to_fixed_parser #(
    parameter int unsigned FRACTION_DIGITS = dtfp_pkg::FRACTION_DIGITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  dtfp_pkg::t_in_req  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output dtfp_pkg::t_out_req o_out_data
);
    import dtfp_pkg::*;

    logic  snap_valid;
    logic  snap_ready;
    t_snap snap;

    // Character parsing.
    dtfp_parse #(
        .FRACTION_DIGITS(FRACTION_DIGITS)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_snap_valid(snap_valid),
        .o_snap      (snap),
        .i_snap_ready(snap_ready)
    );

    // Result forming.
    dtfp_result #(
        .FRACTION_DIGITS(FRACTION_DIGITS)
    ) u_result (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_snap_valid(snap_valid),
        .i_snap      (snap),
        .o_snap_ready(snap_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== design/dtfp_checker.sv =====
// Port-level assertions for the parser and the bind that attaches them.
module dtfp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input dtfp_pkg::t_in_req  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input dtfp_pkg::t_out_req o_out_data
);
    import dtfp_pkg::*;

    // A stalled input request stays and holds its payload.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_data))
        else $error("input request changed while stalled");

    // A stalled result request stays and holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result request changed while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // An overflowing result carries the saturated magnitude.
    a_overflow_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.overflow |->
            (o_out_data.fixed_value == MAG_MAX) ||
            (o_out_data.fixed_value == (VALUE_W'(0) - MAG_MAX)))
        else $error("overflow flagged without saturated value");

    // Back-to-back results: the change flag matches the comparison with the previous one.
    a_changed_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && $past(o_out_valid && !i_out_stall) |->
            o_out_data.value_changed ==
            (o_out_data.fixed_value != $past(o_out_data.fixed_value)))
        else $error("value_changed disagrees with previous result");

endmodule

bind decimal_text_to_fixed_parser dtfp_checker u_checker (.*);
